>>> hw/rtl/sdps_pkg.sv
package sdps_pkg;

  localparam int READOUT_BYTES = 20;
  localparam int RB_AW = $clog2(READOUT_BYTES);
  localparam int MAX_BEATS = 5;
  localparam int BEAT_W = $clog2(MAX_BEATS + 1);

  localparam logic [7:0] OP_READ_ID = 8'h13 | 8'h80;
  localparam logic [7:0] OP_CFG_WR  = 8'h0B | 8'h40;
  localparam logic [7:0] OP_TGT_WR  = 8'h09 | 8'h40;
  localparam logic [7:0] OP_RCH_WR  = 8'h0D | 8'h40;
  localparam logic [7:0] OP_READOUT = 8'h00 | 8'h80;
  localparam logic [7:0] CHIP_ID    = 8'h01;
  localparam logic [4:0] READOUT_RLEN = 5'(READOUT_BYTES % 32);
  localparam logic [8:0] TEMP_OFFSET = 9'd40;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_RX    = 3'd2,
    CMD_DONE  = 3'd3,
    CMD_INIT  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_MEAS = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_INIT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BUSY_ID   = 3'd1,
    ERR_BUSY_CFG  = 3'd2,
    ERR_BUSY_LATE = 3'd3,
    ERR_BAD_ID    = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    CFG_WINDOW_REF  = 3'd0,
    CFG_POWER_SENS  = 3'd1,
    CFG_INIT_RCH    = 3'd2,
    CFG_IRQ_GATE    = 3'd3,
    CFG_TARGET      = 3'd4,
    CFG_RCH_ENABLE  = 3'd5,
    CFG_INIT_WAIT   = 3'd6,
    CFG_SAMPLE_WAIT = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_INIT   = 4'd1,
    PH_READID = 4'd2,
    PH_CFG1   = 4'd3,
    PH_CFG2   = 4'd4,
    PH_DELAY  = 4'd5,
    PH_READ   = 4'd6,
    PH_BUSY1  = 4'd7,
    PH_BUSY2  = 4'd8,
    PH_BUSY3  = 4'd9,
    PH_BADID  = 4'd10,
    PH_ERROR  = 4'd11
  } phase_e;

  typedef struct packed {
    logic signed [8:0]  temperature;
    logic [3:0]         recharge_count;
    logic               recharging;
    logic signed [18:0] ref_value;
    logic               ref_overflow;
    logic signed [18:0] sens_value;
    logic               sens_overflow;
  } meas_t;

  typedef struct packed {
    logic [BEAT_W-1:0]         beats;
    kind_e                     kind;
    logic                      notice_last;
    logic [MAX_BEATS-1:0][7:0] bytes;
    logic [4:0]                rlen;
    err_e                      err;
    meas_t                     meas;
  } burst_t;

endpackage

>>> hw/rtl/sdps_core.sv
module sdps_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [2:0]          cmd_i,
  input  logic                queue_ready_i,
  input  logic [7:0]          sample_count_i,
  input  logic [4:0]          rx_index_i,
  input  logic [7:0]          rx_value_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  output logic                burst_vld_o,
  output sdps_pkg::burst_t    burst_o
);
  import sdps_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] wait_q, wait_d;
  logic [7:0] samples_q, samples_d;
  logic       done_q, done_d;
  logic [7:0] cfg_q [8];
  logic [7:0] store_q [READOUT_BYTES];

  logic       rx_in_range;
  logic [7:0] b0, b1, b3, b4, b5, b6, b7, b8;
  logic       rech;
  meas_t      meas;
  burst_t     burst;
  logic       emit;

  assign rx_in_range = {1'b0, rx_index_i} < 6'(READOUT_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[CFG_WINDOW_REF]  <= 8'd64;
      cfg_q[CFG_POWER_SENS]  <= 8'd121;
      cfg_q[CFG_INIT_RCH]    <= 8'd0;
      cfg_q[CFG_IRQ_GATE]    <= 8'd50;
      cfg_q[CFG_TARGET]      <= 8'd41;
      cfg_q[CFG_RCH_ENABLE]  <= 8'd65;
      cfg_q[CFG_INIT_WAIT]   <= 8'd30;
      cfg_q[CFG_SAMPLE_WAIT] <= 8'd30;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && cmd_e'(cmd_i) == CMD_RX && rx_in_range) begin
      store_q[rx_index_i[RB_AW-1:0]] <= rx_value_i;
    end
  end

  assign b0 = store_q[0];
  assign b1 = store_q[1];
  assign b3 = store_q[3];
  assign b4 = store_q[4];
  assign b5 = store_q[5];
  assign b6 = store_q[6];
  assign b7 = store_q[7];
  assign b8 = store_q[8];
  assign rech = b1[7];

  always_comb begin
    meas.temperature    = $signed({1'b0, b0} - TEMP_OFFSET);
    meas.recharge_count = b1[3:0];
    meas.recharging     = rech;
    meas.ref_overflow   = b5[2];
    meas.sens_overflow  = b8[2];
    meas.ref_value      = '1;
    meas.sens_value     = '1;
    if (!rech && b5[3] && !b5[2]) begin
      meas.ref_value = $signed({1'b0, b5[1:0], b4, b3});
    end
    if (!rech && b8[3] && !b8[2]) begin
      meas.sens_value = $signed({1'b0, b8[1:0], b7, b6});
    end
  end

  always_comb begin
    phase_d   = phase_q;
    wait_d    = wait_q;
    samples_d = samples_q;
    done_d    = done_q;
    emit      = 1'b0;
    burst             = '0;
    burst.kind        = KIND_TX;
    burst.err         = ERR_NONE;
    burst.beats       = BEAT_W'(1);
    if (acc_i) begin
      case (cmd_e'(cmd_i))
        CMD_TICK: begin
          if (wait_q != 8'd0) begin
            wait_d = wait_q - 8'd1;
          end else begin
            case (phase_q)
              PH_BUSY1, PH_BUSY2, PH_BUSY3, PH_BADID: begin
                emit       = 1'b1;
                burst.kind = KIND_ERR;
                case (phase_q)
                  PH_BUSY1: burst.err = ERR_BUSY_ID;
                  PH_BUSY2: burst.err = ERR_BUSY_CFG;
                  PH_BUSY3: burst.err = ERR_BUSY_LATE;
                  default:  burst.err = ERR_BAD_ID;
                endcase
                phase_d = PH_ERROR;
              end
              PH_INIT: begin
                if (!queue_ready_i) begin
                  phase_d = PH_BUSY1;
                end else begin
                  emit           = 1'b1;
                  burst.bytes[0] = OP_READ_ID;
                  burst.rlen     = 5'd1;
                  phase_d        = PH_READID;
                end
              end
              PH_READID: begin
                if (done_q) begin
                  done_d = 1'b0;
                  if (b0 != CHIP_ID) begin
                    phase_d = PH_BADID;
                  end else if (!queue_ready_i) begin
                    phase_d = PH_BUSY2;
                  end else begin
                    emit        = 1'b1;
                    burst.beats = BEAT_W'(5);
                    burst.bytes = {cfg_q[CFG_IRQ_GATE], cfg_q[CFG_INIT_RCH],
                                   cfg_q[CFG_POWER_SENS], cfg_q[CFG_WINDOW_REF], OP_CFG_WR};
                    phase_d     = PH_CFG1;
                  end
                end
              end
              PH_CFG1: begin
                if (done_q) begin
                  done_d = 1'b0;
                  if (!queue_ready_i) begin
                    phase_d = PH_BUSY3;
                  end else begin
                    emit           = 1'b1;
                    burst.beats    = BEAT_W'(2);
                    burst.bytes[0] = OP_TGT_WR;
                    burst.bytes[1] = cfg_q[CFG_TARGET];
                    phase_d        = PH_CFG2;
                  end
                end
              end
              PH_CFG2: begin
                if (done_q) begin
                  done_d = 1'b0;
                  if (!queue_ready_i) begin
                    phase_d = PH_BUSY3;
                  end else begin
                    emit              = 1'b1;
                    burst.beats       = BEAT_W'(3);
                    burst.notice_last = 1'b1;
                    burst.bytes[0]    = OP_RCH_WR;
                    burst.bytes[1]    = cfg_q[CFG_RCH_ENABLE];
                    phase_d           = PH_IDLE;
                  end
                end
              end
              PH_DELAY: begin
                if (!queue_ready_i) begin
                  phase_d = PH_BUSY3;
                end else begin
                  emit           = 1'b1;
                  burst.bytes[0] = OP_READOUT;
                  burst.rlen     = READOUT_RLEN;
                  phase_d        = PH_READ;
                end
              end
              PH_READ: begin
                if (done_q) begin
                  done_d     = 1'b0;
                  emit       = 1'b1;
                  burst.kind = KIND_MEAS;
                  burst.meas = meas;
                  samples_d  = samples_q - 8'd1;
                  if (samples_d != 8'd0) begin
                    wait_d  = cfg_q[CFG_SAMPLE_WAIT];
                    phase_d = PH_DELAY;
                  end else begin
                    phase_d = PH_IDLE;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        CMD_START: begin
          if (phase_q == PH_IDLE && sample_count_i != 8'd0) begin
            samples_d = sample_count_i;
            phase_d   = PH_DELAY;
            wait_d    = 8'd0;
          end
        end
        CMD_DONE: begin
          done_d = 1'b1;
        end
        CMD_INIT: begin
          phase_d = PH_INIT;
          wait_d  = cfg_q[CFG_INIT_WAIT];
          done_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      wait_q    <= 8'd0;
      samples_q <= 8'd0;
      done_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      wait_q    <= wait_d;
      samples_q <= samples_d;
      done_q    <= done_d;
    end
  end

  assign burst_vld_o = emit;
  assign burst_o     = burst;

endmodule

>>> hw/rtl/sdps_out.sv
module sdps_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sdps_pkg::burst_t   burst_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         tx_byte_o,
  output logic [4:0]         read_length_o,
  output logic               last_o,
  output logic [2:0]         error_code_o,
  output logic signed [8:0]  temperature_o,
  output logic [3:0]         recharge_count_o,
  output logic               recharging_o,
  output logic signed [18:0] ref_value_o,
  output logic               ref_overflow_o,
  output logic signed [18:0] sens_value_o,
  output logic               sens_overflow_o
);
  import sdps_pkg::*;

  burst_t            burst_q;
  logic              valid_q, valid_d;
  logic [BEAT_W-1:0] idx_q, idx_d;
  logic              is_last;
  logic              take;
  kind_e             kind;

  assign is_last = idx_q == burst_q.beats - BEAT_W'(1);
  assign take    = valid_q && !out_stall_i;
  assign busy_o  = valid_q && !(take && is_last);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take && is_last) begin
      valid_d = 1'b0;
      idx_d   = '0;
    end else if (take) begin
      idx_d = idx_q + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign kind = (burst_q.notice_last && is_last) ? KIND_INIT : burst_q.kind;

  always_comb begin
    kind_o           = kind;
    last_o           = is_last;
    tx_byte_o        = '0;
    read_length_o    = '0;
    error_code_o     = '0;
    temperature_o    = '0;
    recharge_count_o = '0;
    recharging_o     = 1'b0;
    ref_value_o      = '0;
    ref_overflow_o   = 1'b0;
    sens_value_o     = '0;
    sens_overflow_o  = 1'b0;
    case (kind)
      KIND_TX: begin
        tx_byte_o     = burst_q.bytes[idx_q];
        read_length_o = burst_q.rlen;
      end
      KIND_ERR: begin
        error_code_o = burst_q.err;
      end
      KIND_MEAS: begin
        temperature_o    = burst_q.meas.temperature;
        recharge_count_o = burst_q.meas.recharge_count;
        recharging_o     = burst_q.meas.recharging;
        ref_value_o      = burst_q.meas.ref_value;
        ref_overflow_o   = burst_q.meas.ref_overflow;
        sens_value_o     = burst_q.meas.sens_value;
        sens_overflow_o  = burst_q.meas.sens_overflow;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = valid_q;

endmodule

>>> hw/rtl/spi_dosimeter_poll_sequencer_unit.sv
// SPI dosimeter poll sequencer.
// Input channel (in_valid_i / in_stall_o) carries one command beat: tick,
// start, received readout byte, SPI job done or begin init. Output channel
// (out_valid_o / out_stall_i) carries result beats: SPI transmit bytes with
// their job read length, measurements, error reports and the initialized
// notice; last_o marks the final beat caused by one input beat.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must do so only while the block is idle, as the
// block does not enforce it. The first result beat of an input is valid
// the cycle after it is accepted; its beats leave one per cycle unless the
// receiver stalls, and inputs with no result pass at one per cycle while no
// burst is held. Throughput is set by the single output burst register: the
// next input is taken in the cycle the previous burst's last beat leaves.
// Reset puts the sequencer in the idle phase with counters and the job-done
// flag cleared and all settings at their defaults; readout bytes are
// undefined until received. While out_stall_i is high the current beat holds
// and in_stall_o stays high.
module spi_dosimeter_poll_sequencer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic               queue_ready_i,
  input  logic [7:0]         sample_count_i,
  input  logic [4:0]         rx_index_i,
  input  logic [7:0]         rx_value_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         tx_byte_o,
  output logic [4:0]         read_length_o,
  output logic               last_o,
  output logic [2:0]         error_code_o,
  output logic signed [8:0]  temperature_o,
  output logic [3:0]         recharge_count_o,
  output logic               recharging_o,
  output logic signed [18:0] ref_value_o,
  output logic               ref_overflow_o,
  output logic signed [18:0] sens_value_o,
  output logic               sens_overflow_o
);
  import sdps_pkg::*;

  logic   acc;
  logic   busy;
  logic   burst_vld;
  burst_t burst;

  assign in_stall_o = busy;
  assign acc        = in_valid_i && !busy;

  sdps_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .cmd_i          (cmd_i),
    .queue_ready_i  (queue_ready_i),
    .sample_count_i (sample_count_i),
    .rx_index_i     (rx_index_i),
    .rx_value_i     (rx_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .burst_vld_o    (burst_vld),
    .burst_o        (burst)
  );

  sdps_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (burst_vld),
    .burst_i          (burst),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .tx_byte_o        (tx_byte_o),
    .read_length_o    (read_length_o),
    .last_o           (last_o),
    .error_code_o     (error_code_o),
    .temperature_o    (temperature_o),
    .recharge_count_o (recharge_count_o),
    .recharging_o     (recharging_o),
    .ref_value_o      (ref_value_o),
    .ref_overflow_o   (ref_overflow_o),
    .sens_value_o     (sens_value_o),
    .sens_overflow_o  (sens_overflow_o)
  );

endmodule
